// ----- hdl/acfb_pkg.sv -----
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared types, constants and AES-128 round functions for the CFB decryptor.
// ----------------------------------------------------------------------------
package acfb_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int ROUNDS    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd3;

    typedef struct packed {
        logic [63:0] cipher_low;
        logic [63:0] cipher_high;
        logic        start_req;
    } t_in_item;

    typedef struct packed {
        logic [63:0] plain_low;
        logic [63:0] plain_high;
    } t_out_item;

    // One queued job: ciphertext and the feedback value that it is paired with
    typedef struct packed {
        logic [127:0] cipher;
        logic [127:0] feedback;
    } t_job;

    // Queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key; byte i of the key sits in bits 8i+7:8i
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0]  t;
        logic [127:0] n;
        t[7:0]   = SBOX[k[111:104]] ^ rc;
        t[15:8]  = SBOX[k[119:112]];
        t[23:16] = SBOX[k[127:120]];
        t[31:24] = SBOX[k[103:96]];
        n[31:0]   = k[31:0]   ^ t;
        n[63:32]  = k[63:32]  ^ n[31:0];
        n[95:64]  = k[95:64]  ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    // One encryption round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3, x;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            x  = a0 ^ a1 ^ a2 ^ a3;
            m[8*(4*c)   +: 8] = a0 ^ x ^ xt(a0 ^ a1);
            m[8*(4*c+1) +: 8] = a1 ^ x ^ xt(a1 ^ a2);
            m[8*(4*c+2) +: 8] = a2 ^ x ^ xt(a2 ^ a3);
            m[8*(4*c+3) +: 8] = a3 ^ x ^ xt(a3 ^ a0);
        end
        return (last ? t : m) ^ rk;
    endfunction

endpackage

// ----- hdl/acfb_front.sv -----
// ----------------------------------------------------------------------------
// acfb_front
// Accepts ciphertext items and pairs each with its feedback value.
// ----------------------------------------------------------------------------
module acfb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  acfb_pkg::t_in_item  i_item,
    input  logic [127:0]        i_iv,
    output acfb_pkg::t_job      o_job
);

    logic [127:0] r_fb;
    logic [127:0] n_fb;
    logic [127:0] cipher;

    assign cipher = {i_item.cipher_high, i_item.cipher_low};

    // Pick IV on a message start, else the previous ciphertext
    always_comb begin
        o_job.cipher   = cipher;
        o_job.feedback = i_item.start_req ? i_iv : r_fb;
        n_fb           = i_accept ? cipher : r_fb;
    end

    // Advance feedback on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb <= '0;
        end else begin
            r_fb <= n_fb;
        end
    end

endmodule

// ----- hdl/acfb_queue.sv -----
// ----------------------------------------------------------------------------
// acfb_queue
// Two-entry queue between front end and cipher pipeline.
// ----------------------------------------------------------------------------
module acfb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  acfb_pkg::t_job       i_job,
    input  logic                 i_pop,
    output acfb_pkg::t_job       o_job,
    output acfb_pkg::t_q_status  o_status
);

    acfb_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_status.valid = (r_cnt != 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_job          = r_mem[r_rd];

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ----- hdl/acfb_core.sv -----
// ----------------------------------------------------------------------------
// acfb_core
// Unrolled AES-128 pipeline: an initial key-addition stage, then one round per stage, with on-the-fly key schedule.
// ----------------------------------------------------------------------------
module acfb_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acfb_pkg::t_job       i_job,
    input  logic                 i_job_valid,
    input  logic [127:0]         i_key,
    input  logic                 i_out_stall,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output acfb_pkg::t_out_item  o_out_item
);

    localparam int NST = acfb_pkg::ROUNDS + 1;

    logic [127:0] r_st  [NST];
    logic [127:0] r_key [NST];
    logic [127:0] r_cip [NST];
    logic [NST-1:0] r_vld;

    // Move the whole pipeline unless the last stage is held
    assign o_advance   = !r_vld[NST-1] || !i_out_stall;
    assign o_out_valid = r_vld[NST-1];
    assign o_out_item.plain_low  = r_st[NST-1][63:0];
    assign o_out_item.plain_high = r_st[NST-1][127:64];

    // Initial key addition
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_st[0]  <= i_job.feedback ^ i_key;
            r_key[0] <= i_key;
            r_cip[0] <= i_job.cipher;
        end
    end

    // Round stages; last stage folds in the ciphertext
    for (genvar g = 1; g < NST; g++) begin : g_round
        logic [127:0] rk;
        logic [127:0] rs;
        assign rk = acfb_pkg::key_next(r_key[g-1], acfb_pkg::RCON[g-1]);
        assign rs = acfb_pkg::enc_round(r_st[g-1], rk, g == NST-1);
        always_ff @(posedge i_clk) begin
            if (o_advance) begin
                r_st[g]  <= (g == NST-1) ? (rs ^ r_cip[g-1]) : rs;
                r_key[g] <= rk;
                r_cip[g] <= r_cip[g-1];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (o_advance) begin
            r_vld <= {r_vld[NST-2:0], i_job_valid};
        end
    end

endmodule

// ----- hdl/aes128_cfb_block_decrypt_top.sv -----
// ----------------------------------------------------------------------------
// aes128_cfb_block_decrypt_top
// AES-128 CFB-128 decryptor: one ciphertext block in, one plaintext block out.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_low/key_high/iv_low/iv_high through the cfg channel (index 0..3)
//   while no item is in flight; o_cfg_ready is always high.
//   Input items (i_in_valid / o_in_stall) carry a ciphertext block and
//   start_req; start_req pairs the block with the IV, otherwise with the
//   previous block's ciphertext.
//   Output items (o_out_valid / i_out_stall) carry the plaintext block.
// Throughput: one item per cycle while the output is not stalled, through the
//   eleven-stage unrolled AES pipeline (initial key addition, then one round
//   and one key-schedule step per stage). Path: an accepted item lands in
//   the queue at the accept edge and then passes the 11 pipeline stages.
// Stall: a held output freezes the pipeline; the two-entry queue keeps
//   taking items until full, then raises o_in_stall.
// Reset: clears key, IV and feedback to zero and empties queue and pipeline.
// ----------------------------------------------------------------------------
module aes128_cfb_block_decrypt_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  acfb_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output acfb_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [acfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    logic [63:0] r_key_low, r_key_high, r_iv_low, r_iv_high;
    logic                 in_accept;
    logic                 advance;
    logic                 pop;
    acfb_pkg::t_job       front_job;
    acfb_pkg::t_job       q_job;
    acfb_pkg::t_q_status  q_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_stat.full;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign pop         = advance && q_stat.valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                acfb_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                acfb_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                acfb_pkg::REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                acfb_pkg::REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_iv     ({r_iv_high, r_iv_low}),
        .o_job    (front_job)
    );

    acfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (q_job),
        .o_status (q_stat)
    );

    acfb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (q_stat.valid),
        .i_key       ({r_key_high, r_key_low}),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data)
    );

`ifndef SYNTHESIS
    // An accepted item leaves the queue non-empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> q_stat.valid) else $error("queue empty after push");

    // Input is held back only while jobs are waiting
    a_stall_has_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_stat.valid) else $error("stall with empty queue");

    // A delivered result always moves the pipeline
    a_take_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |-> advance) else $error("pipeline stuck");
`endif

endmodule
